/* rtl/core/ttst_pkg.sv */
// shared constants, command codes and controller command struct
// for the task timing statistics table; no dependencies
package ttst_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 16;

  localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

  localparam int CMD_W   = 2;
  localparam int KEYIN_W = 16;
  localparam int TIME_W  = 32;
  localparam int IDX_W   = 4;
  localparam int TCNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [TIME_W-1:0] TIME_ALL_ONES = '1;

  typedef struct packed {
    logic load_req;   // latch the request beat
    logic lookup;     // register key search result
    logic commit;     // update table and load result register
  } ttst_cmd_t;

endpackage

/* rtl/core/ttst_if.sv */
// valid/ready channel interfaces for request, result and config beats
// depends on ttst_pkg
interface ttst_req_if import ttst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [KEYIN_W-1:0] task_id;
  logic [TIME_W-1:0]  exec_time;
  logic [IDX_W-1:0]   entry_index;

  modport source (output valid, command, task_id, exec_time, entry_index, input ready);
  modport sink   (input valid, command, task_id, exec_time, entry_index, output ready);
endinterface

interface ttst_rsp_if import ttst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               entry_valid;
  logic [IDX_W-1:0]   slot;
  logic [KEYIN_W-1:0] entry_key;
  logic [TIME_W-1:0]  last_time;
  logic [TIME_W-1:0]  min_time;
  logic [TIME_W-1:0]  max_time;
  logic [TIME_W-1:0]  call_count;
  logic [TCNT_W-1:0]  task_count;

  modport source (output valid, entry_valid, slot, entry_key, last_time, min_time,
                  max_time, call_count, task_count, input ready);
  modport sink   (input valid, entry_valid, slot, entry_key, last_time, min_time,
                  max_time, call_count, task_count, output ready);
endinterface

interface ttst_cfg_if ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/ttst_ctrl.sv */
// sequencing state machine: accept, lookup, update/commit, result handshake
// depends on ttst_pkg
module ttst_ctrl import ttst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output ttst_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE
  } state_t;

  state_t state;
  logic   out_valid;

  always_comb begin
    req_ready    = (state == S_IDLE);
    cmd.load_req = req_ready && req_valid;
    cmd.lookup   = (state == S_LOOKUP);
    // commit only when the result register is free or being drained
    cmd.commit   = (state == S_UPDATE) && (!out_valid || rsp_ready);
  end

  assign rsp_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) state <= S_LOOKUP;
        end
        S_LOOKUP: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (cmd.commit) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/ttst_dpath.sv */
// datapath: request registers, entry stores, parallel key search,
// statistics update and result register; depends on ttst_pkg
module ttst_dpath import ttst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ttst_cmd_t          cmd,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  logic [CMD_W-1:0]   command,
  input  logic [KEYIN_W-1:0] task_id,
  input  logic [TIME_W-1:0]  exec_time,
  input  logic [IDX_W-1:0]   entry_index,
  output logic               entry_valid,
  output logic [IDX_W-1:0]   slot,
  output logic [KEYIN_W-1:0] entry_key,
  output logic [TIME_W-1:0]  last_time,
  output logic [TIME_W-1:0]  min_time,
  output logic [TIME_W-1:0]  max_time,
  output logic [TIME_W-1:0]  call_count,
  output logic [TCNT_W-1:0]  task_count
);

  logic                enabled;
  logic [CNT_W-1:0]    occupied;
  logic [CNT_W-1:0]    occupied_next;

  logic [CMD_W-1:0]    cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [TIME_W-1:0]   time_q;
  logic [IDX_W-1:0]    idx_q;

  logic [KEY_BITS-1:0] key_store   [MAX_ENTRIES];
  logic [TIME_W-1:0]   last_store  [MAX_ENTRIES];
  logic [TIME_W-1:0]   min_store   [MAX_ENTRIES];
  logic [TIME_W-1:0]   max_store   [MAX_ENTRIES];
  logic [TIME_W-1:0]   count_store [MAX_ENTRIES];

  logic                hit_c;
  logic [SLOT_W-1:0]   hit_slot_c;
  logic                look_hit;
  logic                look_new;
  logic [SLOT_W-1:0]   look_slot;

  logic [SLOT_W-1:0]   rd_slot;
  logic                res_valid;
  logic                wr_en;
  logic [TIME_W-1:0]   new_last;
  logic [TIME_W-1:0]   new_min;
  logic [TIME_W-1:0]   new_max;
  logic [TIME_W-1:0]   new_count;
  logic [KEY_BITS-1:0] res_key;
  logic [TIME_W-1:0]   res_last;
  logic [TIME_W-1:0]   res_min;
  logic [TIME_W-1:0]   res_max;
  logic [TIME_W-1:0]   res_count;

  // parallel compare over occupied slots, lowest matching slot wins
  always_comb begin
    hit_c      = 1'b0;
    hit_slot_c = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if ((32'(i) < 32'(occupied)) && (key_store[i] == key_q)) begin
        hit_c      = 1'b1;
        hit_slot_c = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    rd_slot       = (cmd_q == CMD_READ) ? SLOT_W'(idx_q) : look_slot;
    occupied_next = occupied;
    res_valid     = 1'b0;
    wr_en         = 1'b0;
    new_last      = time_q;
    new_count     = count_store[rd_slot] + 32'd1;
    new_min       = (time_q < min_store[rd_slot]) ? time_q : min_store[rd_slot];
    new_max       = (time_q > max_store[rd_slot]) ? time_q : max_store[rd_slot];
    if (look_new) begin
      // fresh entry: min from all ones, max from zero, count from zero
      new_count = 32'd1;
      new_min   = time_q;
      new_max   = time_q;
    end
    res_key   = key_store[rd_slot];
    res_last  = last_store[rd_slot];
    res_min   = min_store[rd_slot];
    res_max   = max_store[rd_slot];
    res_count = count_store[rd_slot];
    case (cmd_q)
      CMD_RECORD: begin
        if (enabled && (look_hit || look_new)) begin
          res_valid = 1'b1;
          wr_en     = 1'b1;
          // a new slot is written at this same edge, so take the key from the request
          res_key   = key_q;
          res_last  = new_last;
          res_min   = new_min;
          res_max   = new_max;
          res_count = new_count;
          if (look_new) occupied_next = occupied + CNT_W'(1);
        end
      end
      CMD_READ: begin
        res_valid = (32'(idx_q) < 32'(occupied)) && (32'(idx_q) < 32'(MAX_ENTRIES));
      end
      CMD_CLEAR: begin
        occupied_next = '0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled  <= 1'b1;
      occupied <= '0;
    end else begin
      if (cfg_we) enabled <= cfg_data;
      if (cmd.commit) occupied <= occupied_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cmd_q  <= command;
      key_q  <= KEY_BITS'(task_id);
      time_q <= exec_time;
      idx_q  <= entry_index;
    end
    if (cmd.lookup) begin
      look_hit  <= hit_c;
      look_new  <= !hit_c && (32'(occupied) < 32'(MAX_ENTRIES));
      look_slot <= hit_c ? hit_slot_c : SLOT_W'(occupied);
    end
    if (cmd.commit) begin
      if (wr_en) begin
        key_store[rd_slot]   <= key_q;
        last_store[rd_slot]  <= new_last;
        min_store[rd_slot]   <= new_min;
        max_store[rd_slot]   <= new_max;
        count_store[rd_slot] <= new_count;
      end
      entry_valid <= res_valid;
      slot        <= res_valid ? IDX_W'(rd_slot) : '0;
      entry_key   <= res_valid ? KEYIN_W'(res_key) : '0;
      last_time   <= res_valid ? res_last : '0;
      min_time    <= res_valid ? res_min : '0;
      max_time    <= res_valid ? res_max : '0;
      call_count  <= res_valid ? res_count : '0;
      task_count  <= TCNT_W'(occupied_next);
    end
  end

endmodule

/* rtl/core/task_timing_stats_table_unit.sv */
// task timing statistics table: per-task last/min/max/count of exec time
// a request passes key search and update before its result is registered;
// the next request is accepted only after this one commits; a result still
// waiting on rsp.ready holds the update and stalls the next request
// reset (rst, synchronous): table empty, profiling enabled; no clearing pass
// depends on ttst_pkg, ttst_if, ttst_ctrl, ttst_dpath
module task_timing_stats_table_unit import ttst_pkg::*; (
  input logic      clk,
  input logic      rst,
  ttst_req_if.sink   req,
  ttst_rsp_if.source rsp,
  ttst_cfg_if.sink   cfg
);

  ttst_cmd_t cmd;

  assign cfg.ready = 1'b1;

  ttst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  ttst_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg.valid && cfg.ready),
    .cfg_data    (cfg.data),
    .command     (req.command),
    .task_id     (req.task_id),
    .exec_time   (req.exec_time),
    .entry_index (req.entry_index),
    .entry_valid (rsp.entry_valid),
    .slot        (rsp.slot),
    .entry_key   (rsp.entry_key),
    .last_time   (rsp.last_time),
    .min_time    (rsp.min_time),
    .max_time    (rsp.max_time),
    .call_count  (rsp.call_count),
    .task_count  (rsp.task_count)
  );

endmodule
